// File: design/spk_pkg.sv
// Shared constants and a helper for the symbol to byte packer.
package spk_pkg;

   localparam int unsigned BYTE_BITS = 8;
   localparam int unsigned K_WIDTH   = 4;
   localparam int unsigned FILL_W    = $clog2(BYTE_BITS);

   localparam logic [K_WIDTH-1:0] K_MIN   = K_WIDTH'(1);
   localparam logic [K_WIDTH-1:0] K_MAX   = K_WIDTH'(BYTE_BITS);
   localparam logic [K_WIDTH-1:0] K_RESET = K_WIDTH'(1);

   // ones in the low n bits, n in 0..8
   function automatic logic [BYTE_BITS-1:0] low_mask(input logic [K_WIDTH-1:0] n);
      logic [2*BYTE_BITS-1:0] wide;
      wide = ((2*BYTE_BITS)'(1) << n) - (2*BYTE_BITS)'(1);
      return wide[BYTE_BITS-1:0];
   endfunction

endpackage

// File: design/symbol_to_byte_packer.sv
// Symbol to byte packer: k-bit symbols in, MSB-first packed bytes out.
//
// req_* carries one symbol per request; req_tlast marks the final symbol of a
// stream and flushes any partial byte, right-aligned, with rsp_tlast set.
// rsp_* carries packed bytes, earlier symbols in the higher bits.
// csr_* writes the symbol width k (1..8); other values are dropped. Write only
// while idle. A new k applies to the next symbol; the accumulator is kept.
//
// Each request is handled in the cycle it is accepted; its bytes appear on
// rsp_* from the next cycle on. A request yields zero, one or two bytes, held
// in a two-entry output buffer. Throughput is one request per cycle while
// each yields at most one byte and the receiver does not stall; a request
// that yields two bytes fills the buffer, and the next request waits until
// one has left the single output port. req_tready is high when the buffer
// is empty, or holds one byte that leaves in the same cycle. When the
// receiver stalls, rsp_* holds and req_tready stays low while any byte is pending.
// Reset clears the accumulator, the bit count and the buffer, and sets k to 1.
module symbol_to_byte_packer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [spk_pkg::BYTE_BITS-1:0] req_tdata,   // [7:0] symbol
   input  logic                          req_tlast,   // end_of_symbols
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [spk_pkg::BYTE_BITS-1:0] rsp_tdata,   // [7:0] data_byte
   output logic                          rsp_tlast,   // last_byte
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [spk_pkg::K_WIDTH-1:0]   csr_data     // bits_per_symbol
);
   import spk_pkg::*;

   logic [K_WIDTH-1:0]   k_ff;
   logic [BYTE_BITS-1:0] acc_ff, acc_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [BYTE_BITS-1:0] slot0_byte_ff, slot1_byte_ff;
   logic                 slot0_last_ff, slot1_last_ff;
   logic [1:0]           cnt_ff;

   logic                 accept, pop;
   logic [BYTE_BITS-1:0] sym;
   logic [K_WIDTH-1:0]   sum, rest, room;
   logic [2*BYTE_BITS-1:0] shifted;
   logic [BYTE_BITS-1:0] r0_byte, r1_byte;
   logic                 r0_last, r1_last;
   logic [1:0]           n_res;
   logic [BYTE_BITS-1:0] acc_mid;
   logic [FILL_W:0]      fill_mid;

   assign pop        = rsp_tvalid & rsp_tready;
   assign req_tready = (cnt_ff == 2'd0) || ((cnt_ff == 2'd1) && rsp_tready);
   assign accept     = req_tvalid & req_tready;
   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = slot0_byte_ff;
   assign rsp_tlast  = slot0_last_ff;
   assign csr_ready  = 1'b1;

   always_comb begin
      sym     = req_tdata & low_mask(k_ff);
      sum     = K_WIDTH'(fill_ff) + k_ff;
      rest    = sum - K_MAX;
      room    = K_MAX - K_WIDTH'(fill_ff);
      r0_byte = '0;
      r0_last = 1'b0;
      r1_byte = '0;
      r1_last = 1'b0;
      n_res   = 2'd0;
      shifted = '0;
      if (sum <= K_MAX) begin
         shifted  = ({{BYTE_BITS{1'b0}}, acc_ff} << k_ff) | (2*BYTE_BITS)'(sym);
         acc_mid  = shifted[BYTE_BITS-1:0];
         fill_mid = sum[FILL_W:0];
         if (sum == K_MAX) begin
            r0_byte  = acc_mid;
            r0_last  = req_tlast;
            n_res    = 2'd1;
            acc_mid  = '0;
            fill_mid = '0;
         end
      end else begin
         // straddle: high bits finish this byte, low bits start the next
         shifted  = ({{BYTE_BITS{1'b0}}, acc_ff} << room) | (2*BYTE_BITS)'(sym >> rest);
         r0_byte  = shifted[BYTE_BITS-1:0];
         n_res    = 2'd1;
         acc_mid  = sym & low_mask(rest);
         fill_mid = rest[FILL_W:0];
      end
      acc_in  = acc_mid;
      fill_in = fill_mid[FILL_W-1:0];
      if (req_tlast) begin
         if (fill_mid != '0) begin
            if (n_res == 2'd0) begin
               r0_byte = acc_mid;
               r0_last = 1'b1;
            end else begin
               r1_byte = acc_mid;
               r1_last = 1'b1;
            end
            n_res = n_res + 2'd1;
         end
         acc_in  = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff    <= K_RESET;
         acc_ff  <= '0;
         fill_ff <= '0;
         cnt_ff  <= 2'd0;
      end else begin
         if (csr_valid && csr_ready && (csr_data >= K_MIN) && (csr_data <= K_MAX)) begin
            k_ff <= csr_data;
         end
         if (accept) begin
            acc_ff  <= acc_in;
            fill_ff <= fill_in;
            cnt_ff  <= n_res;
         end else if (pop) begin
            cnt_ff  <= cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot0_byte_ff <= r0_byte;
         slot0_last_ff <= r0_last;
         slot1_byte_ff <= r1_byte;
         slot1_last_ff <= r1_last;
      end else if (pop) begin
         slot0_byte_ff <= slot1_byte_ff;
         slot0_last_ff <= slot1_last_ff;
      end
   end

endmodule

// File: design/spk_checker.sv
// Port-level checks for the symbol to byte packer, bound to the top level.
module spk_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic [spk_pkg::BYTE_BITS-1:0] req_tdata,
   input logic                          req_tlast,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [spk_pkg::BYTE_BITS-1:0] rsp_tdata,
   input logic                          rsp_tlast,
   input logic                          csr_valid,
   input logic                          csr_ready,
   input logic [spk_pkg::K_WIDTH-1:0]   csr_data
);
   import spk_pkg::*;

   // stalled output holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   // backpressure only comes from pending output bytes
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req stalled with empty output");

   // reset empties the output buffer
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("output not empty after reset");

   // with an empty buffer and no request, no byte shows up next cycle
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid && !(req_tvalid && req_tready) |=> !rsp_tvalid)
      else $error("byte without request");

endmodule

bind symbol_to_byte_packer spk_checker u_spk_checker (.*);
